>>> hw/rtl/gdd_pkg.sv
// Shared types, constants and calendar helper functions for the day difference block.
`timescale 1ns / 1ps

package gdd_pkg;

    // Field widths fixed by the interface.
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int NUM_W   = 22;

    // Largest year taken as it is; larger years saturate to it.
    localparam logic [YEAR_W-1:0] MAX_YEAR = YEAR_W'(9999);

    // Reciprocal of 100 for a 19-bit shift, exact for operands below 43699.
    localparam int RECIP_100 = 5243;
    localparam int RECIP_SHIFT = 19;

    localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

    // One calendar date: year, then month, then day.
    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } date_t;

    // Month zero reads as January and months past December as December.
    function automatic logic [MONTH_W-1:0] clamp_month(input logic [MONTH_W-1:0] m);
        logic [MONTH_W-1:0] r;
        r = m;
        if (m < MONTH_JAN) begin
            r = MONTH_JAN;
        end else if (m > MONTH_DEC) begin
            r = MONTH_DEC;
        end
        return r;
    endfunction

    // Years above the supported range saturate.
    function automatic logic [YEAR_W-1:0] clamp_year(input logic [YEAR_W-1:0] y);
        return (y > MAX_YEAR) ? MAX_YEAR : y;
    endfunction

    // Days in the months before the given month of a common year.
    function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m);
        logic [8:0] r;
        unique case (m)
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            default: r = 9'd334;
        endcase
        return r;
    endfunction

endpackage

>>> hw/rtl/gdd_day_number.sv
// Maps one clamped date to its day number counted from the start of year zero.
`timescale 1ns / 1ps

module gdd_day_number (
    input  gdd_pkg::date_t                  date,
    output logic [gdd_pkg::NUM_W-1:0]       day_num
);

    localparam int SUM_W  = gdd_pkg::YEAR_W + 1;
    localparam int PROD_W = SUM_W + 13;
    localparam int CENT_W = PROD_W - gdd_pkg::RECIP_SHIFT;

    logic [SUM_W-1:0]  year_plus_99;
    logic [PROD_W-1:0] cent_prod;
    logic [CENT_W-1:0] cent_ceil;
    logic [CENT_W-1:0] quad_cent_ceil;
    logic [SUM_W-1:0]  quad_ceil;
    logic [SUM_W-1:0]  leaps;
    logic              div100;
    logic              leap_year;
    logic [gdd_pkg::NUM_W-1:0] year_days;

    // Ceiling of year / 100 through a constant reciprocal; year / 400 follows from it.
    assign year_plus_99   = SUM_W'(date.year) + SUM_W'(99);
    assign cent_prod      = PROD_W'(year_plus_99) * PROD_W'(gdd_pkg::RECIP_100);
    assign cent_ceil      = cent_prod[PROD_W-1:gdd_pkg::RECIP_SHIFT];
    assign quad_cent_ceil = CENT_W'((cent_ceil + CENT_W'(3)) >> 2);
    assign quad_ceil      = SUM_W'((SUM_W'(date.year) + SUM_W'(3)) >> 2);

    // Leap years in the years before this one, year zero included.
    assign leaps = quad_ceil - SUM_W'(cent_ceil) + SUM_W'(quad_cent_ceil);

    // A multiple of 100 equals 100 times its ceiling quotient.
    assign div100    = (16'(cent_ceil) * 16'd100) == 16'(date.year);
    assign leap_year = (date.year[1:0] == 2'b00) && (!div100 || (cent_ceil[1:0] == 2'b00));

    // Sum of whole years, whole months, the leap day and the day itself.
    assign year_days = gdd_pkg::NUM_W'(date.year) * gdd_pkg::NUM_W'(365)
                     + gdd_pkg::NUM_W'(leaps);
    assign day_num   = year_days
                     + gdd_pkg::NUM_W'(gdd_pkg::days_before_month(date.month))
                     + gdd_pkg::NUM_W'(leap_year && (date.month > gdd_pkg::MONTH_FEB))
                     + gdd_pkg::NUM_W'(date.day);

endmodule

>>> hw/rtl/gdd_compare.sv
// Orders two dates and forms the absolute difference of their day numbers.
`timescale 1ns / 1ps

module gdd_compare (
    input  gdd_pkg::date_t                  first_date,
    input  gdd_pkg::date_t                  second_date,
    input  logic [gdd_pkg::NUM_W-1:0]       first_num,
    input  logic [gdd_pkg::NUM_W-1:0]       second_num,
    output logic [gdd_pkg::NUM_W-1:0]       span,
    output logic                            first_is_later
);

    // The packed struct orders year, then month, then day.
    assign first_is_later = first_date > second_date;

    // Day numbers fit the span width, so the difference never saturates.
    assign span = (first_num > second_num) ? (first_num - second_num)
                                           : (second_num - first_num);

endmodule

>>> hw/rtl/gregorian_day_difference.sv
// Top level: input register, day number logic and result register.
`timescale 1ns / 1ps

// Gives the absolute number of days between two Gregorian dates and a flag that
// is set when the first date is later. Leap years follow the 4/100/400 rule and
// year zero is leap. Months out of range clamp to January or December, years
// above 9999 saturate, and days are not checked. Each pair of dates passes through
// the input register and then the result register, with the calendar arithmetic
// in between. The block takes one transfer in every cycle and stalls only when
// both registers are full and the result side holds off.
module gregorian_day_difference (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [gdd_pkg::DAY_W-1:0]           s_first_day,
    input  logic [gdd_pkg::MONTH_W-1:0]         s_first_month,
    input  logic [gdd_pkg::YEAR_W-1:0]          s_first_year,
    input  logic [gdd_pkg::DAY_W-1:0]           s_second_day,
    input  logic [gdd_pkg::MONTH_W-1:0]         s_second_month,
    input  logic [gdd_pkg::YEAR_W-1:0]          s_second_year,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [gdd_pkg::NUM_W-1:0]           m_day_span,
    output logic                                m_first_is_later
);

    logic                       in_valid_reg;
    logic                       in_valid_next;
    gdd_pkg::date_t             first_reg;
    gdd_pkg::date_t             second_reg;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [gdd_pkg::NUM_W-1:0]  span_reg;
    logic                       later_reg;
    logic                       advance;
    logic                       s_xfer;
    gdd_pkg::date_t             first_clamped;
    gdd_pkg::date_t             second_clamped;
    logic [gdd_pkg::NUM_W-1:0]  first_num;
    logic [gdd_pkg::NUM_W-1:0]  second_num;
    logic [gdd_pkg::NUM_W-1:0]  span;
    logic                       first_is_later;

    // Pipeline flow: the input register moves on when the result register frees up.
    assign advance        = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready        = !in_valid_reg || advance;
    assign s_xfer         = s_valid && s_ready;
    assign in_valid_next  = s_xfer || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_ready);

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register, loaded on each input transfer.
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            first_reg  <= '{year: s_first_year, month: s_first_month, day: s_first_day};
            second_reg <= '{year: s_second_year, month: s_second_month, day: s_second_day};
        end
    end

    // Clamp month and year before any use.
    always_comb begin
        first_clamped        = first_reg;
        first_clamped.month  = gdd_pkg::clamp_month(first_reg.month);
        first_clamped.year   = gdd_pkg::clamp_year(first_reg.year);
        second_clamped       = second_reg;
        second_clamped.month = gdd_pkg::clamp_month(second_reg.month);
        second_clamped.year  = gdd_pkg::clamp_year(second_reg.year);
    end

    gdd_day_number u_first_num (
        .date    (first_clamped),
        .day_num (first_num)
    );

    gdd_day_number u_second_num (
        .date    (second_clamped),
        .day_num (second_num)
    );

    gdd_compare u_compare (
        .first_date     (first_clamped),
        .second_date    (second_clamped),
        .first_num      (first_num),
        .second_num     (second_num),
        .span           (span),
        .first_is_later (first_is_later)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (advance) begin
            span_reg  <= span;
            later_reg <= first_is_later;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_day_span       = span_reg;
    assign m_first_is_later = later_reg;

`ifndef SYNTHESIS
    // Input is refused only when both registers are full and the result is held.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("input stalled while the pipeline could move");

    // A held item in the input register keeps its dates.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(first_reg)
                                        && $stable(second_reg)))
        else $error("stalled input register lost its item");

    // An item leaving the input register shows up as a result next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("advanced item did not reach the result register");

    // Equal clamped dates give a zero span and a clear flag.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (first_clamped == second_clamped)) |=>
            (m_day_span == '0 && !m_first_is_later))
        else $error("equal dates gave a nonzero result");
`endif

endmodule

>>> bench/tb_gregorian_day_difference.sv
// Self-checking testbench for the Gregorian day difference block.
`timescale 1ns / 1ps

module tb_gregorian_day_difference;

    localparam int RANDOM_PAIRS = 600;
    localparam int HOLD_CYCLES  = 48;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int REPORT_LIMIT = 10;
    localparam logic [gdd_pkg::NUM_W-1:0] SPAN_SAT = {gdd_pkg::NUM_W{1'b1}};

    // One input transfer: two raw dates, fields as they go on the wires.
    typedef struct packed {
        gdd_pkg::date_t first_date;
        gdd_pkg::date_t second_date;
    } date_pair_t;

    // One result transfer.
    typedef struct packed {
        logic [gdd_pkg::NUM_W-1:0] span;
        logic                      later;
    } span_result_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic [gdd_pkg::DAY_W-1:0]     s_first_day = '0;
    logic [gdd_pkg::MONTH_W-1:0]   s_first_month = '0;
    logic [gdd_pkg::YEAR_W-1:0]    s_first_year = '0;
    logic [gdd_pkg::DAY_W-1:0]     s_second_day = '0;
    logic [gdd_pkg::MONTH_W-1:0]   s_second_month = '0;
    logic [gdd_pkg::YEAR_W-1:0]    s_second_year = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [gdd_pkg::NUM_W-1:0]     m_day_span;
    logic                          m_first_is_later;

    date_pair_t   date_pair_q[$];
    span_result_t span_expect_q[$];

    logic s_fire = 1'b0;
    int   total_pairs = 0;
    int   directed_pairs = 0;
    int   pairs_sent = 0;
    int   results_seen = 0;
    int   later_seen = 0;
    int   zero_spans = 0;
    int   input_stall_cycles = 0;
    int   bad_results = 0;
    int   cycle_count = 0;
    int   send_gap_left = 0;
    int   recv_stall_left = 0;
    int   hold_left = 0;
    int   holds_done = 0;
    bit   send_calm = 1'b0;
    bit   recv_calm = 1'b0;

    gregorian_day_difference dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_first_day      (s_first_day),
        .s_first_month    (s_first_month),
        .s_first_year     (s_first_year),
        .s_second_day     (s_second_day),
        .s_second_month   (s_second_month),
        .s_second_year    (s_second_year),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_day_span       (m_day_span),
        .m_first_is_later (m_first_is_later)
    );

    // Clock and a single reset pulse at the start of the run.
    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
    end

    // Calendar arithmetic of the predictor.
    function automatic bit leap_year(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned month_length(input int unsigned m);
        case (m)
            2:            return 28;
            4, 6, 9, 11:  return 30;
            default:      return 31;
        endcase
    endfunction

    // Out-of-range months pin to January or December; large years saturate.
    function automatic gdd_pkg::date_t tidy_date(input gdd_pkg::date_t raw);
        gdd_pkg::date_t t;
        t = raw;
        if (raw.month < gdd_pkg::MONTH_JAN) begin
            t.month = gdd_pkg::MONTH_JAN;
        end else if (raw.month > gdd_pkg::MONTH_DEC) begin
            t.month = gdd_pkg::MONTH_DEC;
        end
        if (raw.year > gdd_pkg::MAX_YEAR) begin
            t.year = gdd_pkg::MAX_YEAR;
        end
        return t;
    endfunction

    // Days from the start of year zero; the day of month is added as it is.
    function automatic int unsigned day_number(input gdd_pkg::date_t dt);
        int unsigned y;
        int unsigned n;
        int unsigned i;
        y = dt.year;
        n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
        for (i = 1; i < dt.month; i++) begin
            n += month_length(i);
        end
        if (dt.month > gdd_pkg::MONTH_FEB && leap_year(y)) begin
            n += 1;
        end
        return n + dt.day;
    endfunction

    function automatic span_result_t predict_span(input date_pair_t p);
        gdd_pkg::date_t a;
        gdd_pkg::date_t b;
        int unsigned    na;
        int unsigned    nb;
        int unsigned    diff;
        span_result_t   r;
        a = tidy_date(p.first_date);
        b = tidy_date(p.second_date);
        na = day_number(a);
        nb = day_number(b);
        diff = (na > nb) ? na - nb : nb - na;
        r.span = (diff > SPAN_SAT) ? SPAN_SAT : diff[gdd_pkg::NUM_W-1:0];
        // The flag orders the clamped fields, not the day numbers.
        r.later = (a.year > b.year) ||
                  (a.year == b.year && a.month > b.month) ||
                  (a.year == b.year && a.month == b.month && a.day > b.day);
        return r;
    endfunction

    // Stimulus helpers.
    function automatic gdd_pkg::date_t make_date(input int d, input int m, input int y);
        gdd_pkg::date_t t;
        t.day   = d[gdd_pkg::DAY_W-1:0];
        t.month = m[gdd_pkg::MONTH_W-1:0];
        t.year  = y[gdd_pkg::YEAR_W-1:0];
        return t;
    endfunction

    function automatic gdd_pkg::date_t random_real_date(input int y);
        int m;
        int last_day;
        m = $urandom_range(12, 1);
        last_day = month_length(m) + ((m == 2 && leap_year(y)) ? 1 : 0);
        return make_date($urandom_range(last_day, 1), m, y);
    endfunction

    function automatic gdd_pkg::date_t random_raw_date();
        return make_date($urandom, $urandom, $urandom);
    endfunction

    // Mostly short gaps, a few long ones; none in a calm stretch.
    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(99);
        if (calm || r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(3, 1);
        end else if (r < 97) begin
            return $urandom_range(10, 4);
        end
        return $urandom_range(60, 20);
    endfunction

    task automatic add_pair(input int d1, input int m1, input int y1,
                            input int d2, input int m2, input int y2);
        date_pair_t p;
        p.first_date  = make_date(d1, m1, y1);
        p.second_date = make_date(d2, m2, y2);
        date_pair_q.push_back(p);
    endtask

    // Driver: presents the next pending pair on the falling edge.
    // While the receiver holds off, gaps are skipped so the block fills up.
    always @(negedge aclk) begin
        date_pair_t p;
        if (aresetn && (!s_valid || s_fire)) begin
            if (send_gap_left > 0 && hold_left == 0) begin
                s_valid <= 1'b0;
                send_gap_left <= send_gap_left - 1;
            end else if (date_pair_q.size() > 0) begin
                p = date_pair_q.pop_front();
                s_first_day    <= p.first_date.day;
                s_first_month  <= p.first_date.month;
                s_first_year   <= p.first_date.year;
                s_second_day   <= p.second_date.day;
                s_second_month <= p.second_date.month;
                s_second_year  <= p.second_date.year;
                s_valid <= 1'b1;
                if ($urandom_range(39) == 0) begin
                    send_calm = ~send_calm;
                end
                // Keep offering pairs back to back while the receiver holds off.
                send_gap_left <= (hold_left > 0) ? 0 : pick_gap(send_calm);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, twice in the run, so the block fills and stalls.
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (holds_done < 2 && pairs_sent >= ((holds_done == 0) ? 60 : 350)) begin
            hold_left <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    // Receiver ready with random stalls.
    always @(negedge aclk) begin
        int stall;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready <= 1'b0;
        end else if (recv_stall_left > 0) begin
            m_ready <= 1'b0;
            recv_stall_left <= recv_stall_left - 1;
        end else begin
            if ($urandom_range(79) == 0) begin
                recv_calm = ~recv_calm;
            end
            stall = ($urandom_range(2) == 0) ? pick_gap(recv_calm) : 0;
            m_ready <= (stall == 0);
            recv_stall_left <= (stall > 0) ? stall - 1 : 0;
        end
    end

    // Input side: every accepted pair gets its expected result.
    always @(posedge aclk) begin
        date_pair_t p;
        s_fire <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            p.first_date  = make_date(s_first_day, s_first_month, s_first_year);
            p.second_date = make_date(s_second_day, s_second_month, s_second_year);
            span_expect_q.push_back(predict_span(p));
            pairs_sent <= pairs_sent + 1;
        end
        if (aresetn && s_valid && !s_ready) begin
            input_stall_cycles <= input_stall_cycles + 1;
        end
    end

    // Monitor: each result transfer is checked against the oldest expectation.
    always @(posedge aclk) begin
        span_result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen <= results_seen + 1;
            if (span_expect_q.size() == 0) begin
                if (bad_results < REPORT_LIMIT) begin
                    $display("ERROR: unexpected result span=%0d later=%0b",
                             m_day_span, m_first_is_later);
                end
                bad_results <= bad_results + 1;
            end else begin
                want = span_expect_q.pop_front();
                if (want.later) begin
                    later_seen <= later_seen + 1;
                end
                if (want.span == '0) begin
                    zero_spans <= zero_spans + 1;
                end
                if (m_day_span !== want.span || m_first_is_later !== want.later) begin
                    if (bad_results < REPORT_LIMIT) begin
                        $display("ERROR: result %0d: span exp %0d got %0d, later exp %0b got %0b",
                                 results_seen, want.span, m_day_span,
                                 want.later, m_first_is_later);
                    end
                    bad_results <= bad_results + 1;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("ERROR: timeout after %0d cycles", cycle_count);
            $display("gregorian_day_difference: mismatch");
            $finish;
        end
    end

    // Stimulus, then drain and verdict.
    initial begin
        int             k;
        int             sel;
        int             y;
        date_pair_t     p;
        gdd_pkg::date_t a;

        // Equal dates, the full span both ways, and leap rules around February.
        add_pair(1, 1, 0, 1, 1, 0);
        add_pair(1, 1, 0, 31, 12, 9999);
        add_pair(31, 12, 9999, 1, 1, 0);
        add_pair(29, 2, 2000, 1, 3, 2000);
        add_pair(28, 2, 1900, 1, 3, 1900);
        add_pair(29, 2, 2024, 1, 3, 2023);
        add_pair(1, 1, 1, 31, 12, 0);
        add_pair(1, 3, 0, 28, 2, 0);
        add_pair(1, 1, 100, 31, 12, 99);
        add_pair(1, 1, 400, 31, 12, 399);
        add_pair(10, 1, 8, 10, 1, 4);
        add_pair(31, 4, 2010, 1, 5, 2010);
        // Month zero reads as January, months past December as December.
        add_pair(15, 0, 2021, 15, 1, 2021);
        add_pair(5, 15, 2021, 5, 12, 2021);
        add_pair(7, 13, 1999, 7, 0, 2000);
        // Years above the limit saturate.
        add_pair(1, 6, 16383, 1, 6, 9999);
        add_pair(1, 6, 10000, 31, 5, 9999);
        // Day zero and days past the end of the month count as they are,
        // so the ordering flag may disagree with the day numbers.
        add_pair(0, 3, 2001, 28, 2, 2001);
        add_pair(31, 2, 2023, 3, 3, 2023);
        add_pair(30, 2, 2023, 2, 3, 2023);
        add_pair(31, 2, 2023, 1, 3, 2023);
        // All-ones and all-zeros raw fields, and an alternating pattern.
        add_pair(31, 15, 16383, 0, 0, 0);
        add_pair(0, 0, 0, 31, 15, 16383);
        add_pair(21, 10, 10922, 10, 5, 5461);
        directed_pairs = date_pair_q.size();

        // Random part: mostly real dates, some close together, some raw bits.
        for (k = 0; k < RANDOM_PAIRS; k++) begin
            sel = $urandom_range(99);
            if (sel < 45) begin
                p.first_date  = random_real_date($urandom_range(gdd_pkg::MAX_YEAR));
                p.second_date = random_real_date($urandom_range(gdd_pkg::MAX_YEAR));
            end else if (sel < 70) begin
                y = $urandom_range(gdd_pkg::MAX_YEAR - 2);
                a = random_real_date(y + $urandom_range(2));
                p.first_date  = a;
                p.second_date = random_real_date(y + $urandom_range(2));
                if ($urandom_range(1) == 0) begin
                    p.second_date.year  = a.year;
                    p.second_date.month = a.month;
                    p.second_date.day   = gdd_pkg::DAY_W'($urandom_range(31));
                end
            end else if (sel < 78) begin
                p.first_date  = random_real_date($urandom_range(gdd_pkg::MAX_YEAR));
                p.second_date = p.first_date;
            end else begin
                p.first_date  = random_raw_date();
                p.second_date = ($urandom_range(1) == 0) ? random_raw_date() :
                                random_real_date($urandom_range(gdd_pkg::MAX_YEAR));
                if ($urandom_range(1) == 0) begin
                    p = {p.second_date, p.first_date};
                end
            end
            date_pair_q.push_back(p);
        end
        total_pairs = date_pair_q.size();

        while (pairs_sent < total_pairs) begin
            @(posedge aclk);
        end
        while (span_expect_q.size() > 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Summary: %0d date pairs (%0d directed), %0d results checked,",
                 pairs_sent, directed_pairs, results_seen);
        $display("Summary: %0d with first later, %0d zero spans, input held off %0d cycles,",
                 later_seen, zero_spans, input_stall_cycles);
        $display("Summary: %0d long receiver hold-offs, %0d bad results.",
                 holds_done, bad_results);
        if (bad_results == 0 && span_expect_q.size() == 0 && results_seen == pairs_sent) begin
            $display("gregorian_day_difference: match");
        end else begin
            $display("gregorian_day_difference: mismatch");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/gdd_pkg.sv
hw/rtl/gdd_day_number.sv
hw/rtl/gdd_compare.sv
hw/rtl/gregorian_day_difference.sv
bench/tb_gregorian_day_difference.sv
